// File: rtl/hsv2rgb_pkg.sv
// Package with the pixel types, sector codes and fixed-point constants of the HSV to RGB converter.
package hsv2rgb_pkg;

  // Hue geometry in 1/64 degree units.
  localparam int unsigned HueSector = 3840;
  localparam int unsigned HueFull   = 6 * HueSector;

  // Common denominator of the q and t terms: 255 * 3840.
  localparam int unsigned FracDen   = 255 * HueSector;

  // Field widths.
  localparam int unsigned HueW   = 15;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned RemW   = $clog2(HueSector + 1);
  localparam int unsigned NumW   = $clog2(FracDen + 1);
  localparam int unsigned ProdW  = NumW + ChanW;
  localparam int unsigned QuotW  = 16;

  // Reciprocals for the constant divisions.
  // Division by 15 of a 20-bit value: ceil(2^23 / 15).
  localparam int unsigned Div15Shift = 23;
  localparam int unsigned Div15Mul   = 559241;
  // Division by 255 of a 16-bit value: ceil(2^24 / 255).
  localparam int unsigned Div255Shift = 24;
  localparam int unsigned Div255Mul   = 65794;

  // Hue sector, named by the pair of primaries it spans.
  typedef enum logic [2:0] {
    SECT_RY = 3'd0,
    SECT_YG = 3'd1,
    SECT_GC = 3'd2,
    SECT_CB = 3'd3,
    SECT_BM = 3'd4,
    SECT_MR = 3'd5
  } sector_e;

  // One input item.
  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [ChanW-1:0] saturation;
    logic [ChanW-1:0] brightness;
  } hsv_pixel_t;

  // One result item.
  typedef struct packed {
    logic [ChanW-1:0]   red;
    logic [ChanW-1:0]   green;
    logic [ChanW-1:0]   blue;
    logic [3*ChanW-1:0] grb_word;
  } rgb_pixel_t;

endpackage

// File: rtl/hsv2rgb_div255.sv
// Divider by the constant 255 for values up to 255 * 255, by reciprocal multiplication.
module hsv2rgb_div255
  import hsv2rgb_pkg::*;
(
  input  logic [QuotW-1:0] num_i,
  output logic [ChanW-1:0] quot_o
);

  localparam int unsigned MulW  = $clog2(Div255Mul + 1);
  localparam int unsigned FullW = QuotW + MulW;

  logic [FullW-1:0] prod;

  // The rounded-up reciprocal is exact for every numerator below 66052.
  assign prod   = FullW'(num_i) * FullW'(Div255Mul);
  assign quot_o = prod[Div255Shift +: ChanW];

endmodule

// File: rtl/hsv_to_rgb_pixel.sv
// Top level of the pipelined HSV to RGB pixel converter with packed GRB output.
//
// Converts one pixel per clock while the output is not stalled: an item can be
// accepted in every such cycle, and each result passes through one register stage
// for the sector split, then one for each multiplier level: the saturation product,
// the brightness product, the division by 3840 and the division by 255. Hue is
// given in 1/64 degree units; values of 360 degrees or more are wrapped once.
// The p, q and t channel terms are computed exactly and truncated toward zero.
// Each stage holds while the stage after it is full and stalled, so a stall on
// the output backs up through the pipeline without losing or repeating items.
module hsv_to_rgb_pixel
  import hsv2rgb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  hsv_pixel_t in_pixel_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rgb_pixel_t out_pixel_o
);

  localparam int unsigned NStages = 5;
  localparam int unsigned XW      = ProdW - 8;
  localparam int unsigned Mul15W  = $clog2(Div15Mul + 1);
  localparam int unsigned Full15W = XW + Mul15W;

  // Stage handshake: a stage loads when it is empty or its successor moves.
  logic [NStages-1:0] valid_q;
  logic [NStages-1:0] ready;

  always_comb begin
    ready[NStages-1] = !valid_q[NStages-1] || !out_stall_i;
    for (int k = NStages - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  assign in_stall_o  = !ready[0];
  assign out_valid_o = valid_q[NStages-1];

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NStages; k++) begin
        if (ready[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Stage 1: wrap the hue and split it into sector and remainder.
  logic [HueW-1:0]  hue_wrap;
  logic [HueW-1:0]  sect_base;
  logic [HueW-1:0]  rem_full;
  sector_e          sect_d;
  logic [RemW-1:0]  rem1_q;
  sector_e          sect1_q;
  logic [ChanW-1:0] sat1_q;
  logic [ChanW-1:0] bri1_q;

  always_comb begin
    hue_wrap = (in_pixel_i.hue >= HueW'(HueFull)) ?
               in_pixel_i.hue - HueW'(HueFull) : in_pixel_i.hue;
    if (hue_wrap >= HueW'(5 * HueSector)) begin
      sect_d    = SECT_MR;
      sect_base = HueW'(5 * HueSector);
    end else if (hue_wrap >= HueW'(4 * HueSector)) begin
      sect_d    = SECT_BM;
      sect_base = HueW'(4 * HueSector);
    end else if (hue_wrap >= HueW'(3 * HueSector)) begin
      sect_d    = SECT_CB;
      sect_base = HueW'(3 * HueSector);
    end else if (hue_wrap >= HueW'(2 * HueSector)) begin
      sect_d    = SECT_GC;
      sect_base = HueW'(2 * HueSector);
    end else if (hue_wrap >= HueW'(HueSector)) begin
      sect_d    = SECT_YG;
      sect_base = HueW'(HueSector);
    end else begin
      sect_d    = SECT_RY;
      sect_base = '0;
    end
    rem_full = hue_wrap - sect_base;
  end

  always_ff @(posedge clk_i) begin
    if (ready[0] && in_valid_i) begin
      rem1_q  <= rem_full[RemW-1:0];
      sect1_q <= sect_d;
      sat1_q  <= in_pixel_i.saturation;
      bri1_q  <= in_pixel_i.brightness;
    end
  end

  // Stage 2: saturation products and the numerators of p, q and t.
  logic [NumW-1:0]  prod_q2;
  logic [NumW-1:0]  prod_t2;
  logic [RemW-1:0]  rem_inv;
  logic [NumW-1:0]  numq2_q;
  logic [NumW-1:0]  numt2_q;
  logic [QuotW-1:0] nump2_q;
  sector_e          sect2_q;
  logic [ChanW-1:0] bri2_q;

  always_comb begin
    rem_inv = RemW'(HueSector) - rem1_q;
    prod_q2 = NumW'(sat1_q) * NumW'(rem1_q);
    prod_t2 = NumW'(sat1_q) * NumW'(rem_inv);
  end

  always_ff @(posedge clk_i) begin
    if (ready[1] && valid_q[0]) begin
      numq2_q <= NumW'(FracDen) - prod_q2;
      numt2_q <= NumW'(FracDen) - prod_t2;
      nump2_q <= QuotW'(bri1_q) * QuotW'(ChanW'(255) - sat1_q);
      sect2_q <= sect1_q;
      bri2_q  <= bri1_q;
    end
  end

  // Stage 3: brightness products for q and t; p is finished here.
  logic [ChanW-1:0] p_div;
  logic [ProdW-1:0] xq3_q;
  logic [ProdW-1:0] xt3_q;
  logic [ChanW-1:0] p3_q;
  sector_e          sect3_q;
  logic [ChanW-1:0] bri3_q;

  hsv2rgb_div255 u_div_p (
    .num_i  (nump2_q),
    .quot_o (p_div)
  );

  always_ff @(posedge clk_i) begin
    if (ready[2] && valid_q[1]) begin
      xq3_q   <= ProdW'(bri2_q) * ProdW'(numq2_q);
      xt3_q   <= ProdW'(bri2_q) * ProdW'(numt2_q);
      p3_q    <= p_div;
      sect3_q <= sect2_q;
      bri3_q  <= bri2_q;
    end
  end

  // Stage 4: divide by 3840 as a shift by 8 and a division by 15.
  logic [Full15W-1:0] mq4;
  logic [Full15W-1:0] mt4;
  logic [QuotW-1:0]   aq4_q;
  logic [QuotW-1:0]   at4_q;
  logic [ChanW-1:0]   p4_q;
  sector_e            sect4_q;
  logic [ChanW-1:0]   bri4_q;

  always_comb begin
    mq4 = Full15W'(xq3_q[ProdW-1:8]) * Full15W'(Div15Mul);
    mt4 = Full15W'(xt3_q[ProdW-1:8]) * Full15W'(Div15Mul);
  end

  always_ff @(posedge clk_i) begin
    if (ready[3] && valid_q[2]) begin
      aq4_q   <= mq4[Div15Shift +: QuotW];
      at4_q   <= mt4[Div15Shift +: QuotW];
      p4_q    <= p3_q;
      sect4_q <= sect3_q;
      bri4_q  <= bri3_q;
    end
  end

  // Stage 5: divide by 255, route the channels by sector and pack.
  logic [ChanW-1:0] q_div;
  logic [ChanW-1:0] t_div;
  rgb_pixel_t       pix_d;
  rgb_pixel_t       pix_q;

  hsv2rgb_div255 u_div_q (
    .num_i  (aq4_q),
    .quot_o (q_div)
  );

  hsv2rgb_div255 u_div_t (
    .num_i  (at4_q),
    .quot_o (t_div)
  );

  always_comb begin
    pix_d = '0;
    case (sect4_q)
      SECT_RY: begin
        pix_d.red = bri4_q; pix_d.green = t_div; pix_d.blue = p4_q;
      end
      SECT_YG: begin
        pix_d.red = q_div; pix_d.green = bri4_q; pix_d.blue = p4_q;
      end
      SECT_GC: begin
        pix_d.red = p4_q; pix_d.green = bri4_q; pix_d.blue = t_div;
      end
      SECT_CB: begin
        pix_d.red = p4_q; pix_d.green = q_div; pix_d.blue = bri4_q;
      end
      SECT_BM: begin
        pix_d.red = t_div; pix_d.green = p4_q; pix_d.blue = bri4_q;
      end
      default: begin
        pix_d.red = bri4_q; pix_d.green = p4_q; pix_d.blue = q_div;
      end
    endcase
    pix_d.grb_word = {pix_d.green, pix_d.red, pix_d.blue};
  end

  always_ff @(posedge clk_i) begin
    if (ready[4] && valid_q[3]) begin
      pix_q <= pix_d;
    end
  end

  assign out_pixel_o = pix_q;

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the pipelined HSV to RGB pixel converter.
`timescale 1ns / 100ps

import hsv2rgb_pkg::*;

// Predicts the RGB pixel of each accepted HSV item and checks the results in order.
class rgb_checker;
  rgb_pixel_t expected_rgb[$];
  int         fail_count = 0;

  // Prints one line per mismatch and counts it.
  task note_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    fail_count++;
  endtask

  // Converts one pixel exactly, truncating each channel term toward zero.
  function rgb_pixel_t predict_rgb(hsv_pixel_t px);
    int unsigned hue_u;
    int unsigned sat;
    int unsigned val;
    int unsigned rem;
    int unsigned p;
    int unsigned q;
    int unsigned t;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    rgb_pixel_t  res;
    hue_u = px.hue;
    sat   = px.saturation;
    val   = px.brightness;
    if (sat == 0) begin
      // Zero saturation gives grey whatever the hue.
      r = 8'(val);
      g = 8'(val);
      b = 8'(val);
    end else begin
      // Hue at or past a full turn is wrapped once.
      if (hue_u >= HueFull) begin
        hue_u = hue_u - HueFull;
      end
      rem = hue_u % HueSector;
      p   = (val * (255 - sat)) / 255;
      q   = (val * (FracDen - sat * rem)) / FracDen;
      t   = (val * (FracDen - sat * (HueSector - rem))) / FracDen;
      case (sector_e'(hue_u / HueSector))
        SECT_RY: begin r = 8'(val); g = 8'(t);   b = 8'(p);   end
        SECT_YG: begin r = 8'(q);   g = 8'(val); b = 8'(p);   end
        SECT_GC: begin r = 8'(p);   g = 8'(val); b = 8'(t);   end
        SECT_CB: begin r = 8'(p);   g = 8'(q);   b = 8'(val); end
        SECT_BM: begin r = 8'(t);   g = 8'(p);   b = 8'(val); end
        default: begin r = 8'(val); g = 8'(p);   b = 8'(q);   end
      endcase
    end
    res.red      = r;
    res.green    = g;
    res.blue     = b;
    res.grb_word = {g, r, b};
    return res;
  endfunction

  // Records the expected result of an accepted input item.
  function void note_input(hsv_pixel_t px);
    expected_rgb.push_back(predict_rgb(px));
  endfunction

  // Compares an accepted result with the oldest expectation, field by field.
  task check_result(rgb_pixel_t got);
    rgb_pixel_t exp_px;
    if (expected_rgb.size() == 0) begin
      note_mismatch($sformatf("unexpected result %h", got));
    end else begin
      exp_px = expected_rgb.pop_front();
      if (got.red !== exp_px.red)
        note_mismatch($sformatf("red got %h want %h", got.red, exp_px.red));
      if (got.green !== exp_px.green)
        note_mismatch($sformatf("green got %h want %h", got.green, exp_px.green));
      if (got.blue !== exp_px.blue)
        note_mismatch($sformatf("blue got %h want %h", got.blue, exp_px.blue));
      if (got.grb_word !== exp_px.grb_word)
        note_mismatch($sformatf("grb_word got %h want %h", got.grb_word, exp_px.grb_word));
    end
  endtask

  function int pending();
    return expected_rgb.size();
  endfunction
endclass

module testbench;

  localparam int RandomItems   = 1400;
  localparam int CalmTail      = 200;
  localparam int DrainCycles   = 20;
  localparam int WatchdogLimit = 2000;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  hsv_pixel_t in_pixel_i  = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  rgb_pixel_t out_pixel_o;

  rgb_checker sb = new;
  bit         idle_on = 1'b1;
  int         stall_left = 0;
  int         quiet_cycles = 0;

  hsv_to_rgb_pixel i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_pixel_i (in_pixel_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_pixel_o(out_pixel_o)
  );

  always #10 clk_i = ~clk_i;

  // Offers one item, with an optional idle gap first, and waits until it is taken.
  task send_pixel(input logic [14:0] hue, input logic [7:0] sat, input logic [7:0] val);
    hsv_pixel_t px;
    int         gap;
    px.hue        = hue;
    px.saturation = sat;
    px.brightness = val;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_pixel_i <= px;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(px);
  endtask

  // Hue mostly in range, with sector edges and wrapped values mixed in.
  function logic [14:0] random_hue();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      6: return 15'(HueSector * $urandom_range(0, 6) + $urandom_range(0, 2) - 1);
      7: return 15'($urandom_range(HueFull, 32767));
      8: return 15'($urandom_range(0, 32767));
      default: return 15'($urandom_range(0, HueFull - 1));
    endcase
  endfunction

  // Channel fraction with its extremes favored.
  function logic [7:0] random_chan();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Result side: check accepted results, then decide the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(out_pixel_o);
    end
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog on cycles in which no item moves on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Stimulus: directed corners, then random pixels in phases of idling and calm.
  initial begin
    int k;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Grey, including a hue far above a full turn.
    send_pixel(15'd0, 8'd0, 8'd0);
    send_pixel(15'd32767, 8'd0, 8'd255);
    send_pixel(15'd12345, 8'd0, 8'd128);
    // Each sector at its start and its last step, full saturation and value.
    send_pixel(15'd0, 8'd255, 8'd255);
    send_pixel(15'd3839, 8'd255, 8'd255);
    send_pixel(15'd3840, 8'd255, 8'd255);
    send_pixel(15'd7679, 8'd255, 8'd255);
    send_pixel(15'd7680, 8'd255, 8'd255);
    send_pixel(15'd11519, 8'd255, 8'd255);
    send_pixel(15'd11520, 8'd255, 8'd255);
    send_pixel(15'd15359, 8'd255, 8'd255);
    send_pixel(15'd15360, 8'd255, 8'd255);
    send_pixel(15'd19199, 8'd255, 8'd255);
    send_pixel(15'd19200, 8'd255, 8'd255);
    send_pixel(15'd23039, 8'd255, 8'd255);
    // Hue wrapped once: exactly a full turn, just past it, and the field maximum.
    send_pixel(15'd23040, 8'd255, 8'd255);
    send_pixel(15'd23041, 8'd200, 8'd100);
    send_pixel(15'd32767, 8'd255, 8'd255);
    // Mid-sector with small saturation, zero value and odd mixes.
    send_pixel(15'd1920, 8'd1, 8'd255);
    send_pixel(15'd9600, 8'd255, 8'd0);
    send_pixel(15'd17280, 8'd128, 8'd1);
    send_pixel(15'd21119, 8'd77, 8'd201);

    for (k = 0; k < RandomItems; k++) begin
      idle_on = (k < RandomItems - CalmTail) && ((k / 150) % 3 != 2);
      send_pixel(random_hue(), random_chan(), random_chan());
    end
    in_valid_i <= 1'b0;
    idle_on = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
